/* rtl/kmms_pkg.sv */
// Shared types and constants for the k-way merge minimum selector.
`default_nettype none
package kmms_pkg;

   localparam int KEY_W = 64;
   localparam logic [KEY_W-1:0] KEY_ENDED = 64'hffff_ffff_ffff_ffff;
   localparam logic [KEY_W-1:0] KEY_UNMAPPED = 64'hffff_ffff_ffff_fffe;
   localparam logic [15:0] REVERSE_BIT = 16'h0010;
   localparam int REF_SHIFT = 40;
   localparam int POS_SHIFT = 8;
   localparam int CMD_DEPTH = 2;

   // One classified load, passed from the front end to the merge engine.
   typedef struct packed {
      logic [3:0]       source_index;
      logic             out_of_range;
      logic [KEY_W-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic [3:0] selected_source;
      logic       all_done;
      logic       load_error;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/kmms_front.sv */
// Front end: source count register, key packing and range check of each load.
`default_nettype none
module kmms_front #(
   parameter int MAX_SOURCES = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [3:0]                          req_source_index,
   input  wire                                 req_end_of_source,
   input  wire  signed [24:0]                  req_reference_id,
   input  wire  signed [31:0]                  req_position,
   input  wire  [15:0]                         req_record_flags,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [4:0]                          csr_active_sources,
   output kmms_pkg::cmd_type                   cmd,
   output logic [$clog2(MAX_SOURCES+1)-1:0]    active_count
);
   import kmms_pkg::*;

   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   logic [4:0]       csr_ff;
   logic [KEY_W-1:0] rec_key;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= 5'd2;
      end else if (csr_valid) begin
         csr_ff <= csr_active_sources;
      end
   end

   // Clamp the programmed count into [2, MAX_SOURCES].
   always_comb begin
      if (int'(csr_ff) < 2) begin
         active_count = CNT_W'(2);
      end else if (int'(csr_ff) > MAX_SOURCES) begin
         active_count = CNT_W'(MAX_SOURCES);
      end else begin
         active_count = CNT_W'(csr_ff);
      end
   end

   always_comb begin
      if (req_reference_id[24] || req_position[31]) begin
         rec_key = KEY_UNMAPPED;
      end else begin
         rec_key = (KEY_W'(req_reference_id[23:0]) << REF_SHIFT)
                 | (KEY_W'(unsigned'(req_position)) << POS_SHIFT)
                 | KEY_W'(req_record_flags & REVERSE_BIT);
      end
   end

   always_comb begin
      cmd.source_index = req_source_index;
      cmd.out_of_range = int'(req_source_index) >= int'(active_count);
      cmd.key          = req_end_of_source ? KEY_ENDED : rec_key;
   end

endmodule
`default_nettype wire

/* rtl/kmms_cmd_fifo.sv */
// Short command queue between the front end and the merge engine.
`default_nettype none
module kmms_cmd_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   output logic               full,
   input  kmms_pkg::cmd_type  din,
   input  wire                pop,
   output logic               empty,
   output kmms_pkg::cmd_type  dout
);
   import kmms_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            entry_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == CNT_W'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/kmms_back.sv */
// Merge engine: head key store, loaded mask, registered minimum tree, result register.
`default_nettype none
module kmms_back #(
   parameter int MAX_SOURCES = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [$clog2(MAX_SOURCES+1)-1:0]   active_count,
   input  wire                                cmd_valid,
   input  kmms_pkg::cmd_type                  cmd,
   output logic                               cmd_pop,
   output logic                               rsp_valid,
   input  wire                                rsp_pop,
   output kmms_pkg::rsp_type                  rsp
);
   import kmms_pkg::*;

   localparam int LEVELS = $clog2(MAX_SOURCES);
   localparam int LEAVES = 2 ** LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int IDX_W  = (LEVELS > 0) ? LEVELS : 1;
   localparam int CW     = $clog2(LEVELS + 1);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } node_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SETTLE = 2'b10
   } state_type;

   logic [KEY_W-1:0]       key_ff [MAX_SOURCES];
   node_type               node_ff [LEAVES-1];
   node_type               tree [NODES];
   logic [MAX_SOURCES-1:0] loaded_ff, loaded_in;
   logic [MAX_SOURCES-1:0] hit_vec, need_vec, sel_vec;
   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   key_wr;
   node_type               root;

   always_comb begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
         hit_vec[i]  = int'(cmd.source_index) == i;
         need_vec[i] = i < int'(active_count);
         sel_vec[i]  = int'(root.idx) == i;
      end
   end

   // Heap layout: node j has children 2j+1 and 2j+2; leaves start at LEAVES-1.
   always_comb begin
      for (int j = 0; j < LEAVES - 1; j++) begin
         tree[j] = node_ff[j];
      end
      for (int i = 0; i < LEAVES; i++) begin
         tree[LEAVES-1+i].idx = IDX_W'(i);
         if (i < MAX_SOURCES && i < int'(active_count)) begin
            tree[LEAVES-1+i].key = key_ff[i];
         end else begin
            tree[LEAVES-1+i].key = KEY_ENDED;
         end
      end
   end

   assign root = tree[0];

   // Each level is registered; lower index wins a tie.
   always_ff @(posedge clock) begin
      for (int j = 0; j < LEAVES - 1; j++) begin
         if (tree[2*j+1].key <= tree[2*j+2].key) begin
            node_ff[j] <= tree[2*j+1];
         end else begin
            node_ff[j] <= tree[2*j+2];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
         if (key_wr && hit_vec[i]) begin
            key_ff[i] <= cmd.key;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      loaded_in    = loaded_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      key_wr       = 1'b0;
      cmd_pop      = 1'b0;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !out_valid_ff) begin
               cmd_pop = 1'b1;
               if (cmd.out_of_range || (|(loaded_ff & hit_vec))) begin
                  out_valid_in = 1'b1;
                  rsp_in       = '{selected_source: '0, all_done: 1'b0, load_error: 1'b1};
               end else begin
                  key_wr    = 1'b1;
                  loaded_in = loaded_ff | hit_vec;
                  if ((loaded_in & need_vec) == need_vec) begin
                     state_in = ST_SETTLE;
                     cnt_in   = CW'(LEVELS);
                  end
               end
            end
         end
         ST_SETTLE: begin
            // Root reflects the new key set once every tree level has turned over.
            if (cnt_ff == '0) begin
               state_in     = ST_IDLE;
               out_valid_in = 1'b1;
               if (root.key == KEY_ENDED) begin
                  loaded_in = '0;
                  rsp_in    = '{selected_source: '0, all_done: 1'b1, load_error: 1'b0};
               end else begin
                  loaded_in = loaded_ff & ~sel_vec;
                  rsp_in    = '{selected_source: 4'(root.idx), all_done: 1'b0,
                                load_error: 1'b0};
               end
            end else begin
               cnt_in = CW'(cnt_ff - 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         loaded_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         loaded_ff    <= loaded_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = rsp_ff;

   a_settle_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETTLE |-> !out_valid_ff)
      else $error("result register busy during tree settle");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETTLE && cnt_ff == '0 && root.key == KEY_ENDED)
      |=> (loaded_ff == '0 && out_valid_ff && rsp_ff.all_done))
      else $error("done result did not clear loaded mask");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE && !out_valid_ff && cmd_valid))
      else $error("command taken while engine busy");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(rsp_ff.all_done && rsp_ff.load_error))
      else $error("done and error flagged together");

endmodule
`default_nettype wire

/* rtl/kway_merge_min_select_top.sv */
// A rejected load passes through the command queue and then the result register; a load that
// completes the set of heads is written to the head key store, the minimum tree settles level by
// level, and the selection is then registered in the result register. The engine takes one
// load per cycle until the set is complete while no result waits and the tree is not settling;
// a waiting result stalls the engine until popped. Reset is synchronous: clears loaded mask,
// queues and result, count register returns to 2; head keys are not reset.
`default_nettype none
module kway_merge_min_select_top #(
   parameter int MAX_SOURCES = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  wire  [3:0]          req_source_index,
   input  wire                 req_end_of_source,
   input  wire  signed [24:0]  req_reference_id,
   input  wire  signed [31:0]  req_position,
   input  wire  [15:0]         req_record_flags,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic [3:0]          rsp_selected_source,
   output logic                rsp_all_done,
   output logic                rsp_load_error,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [4:0]          csr_active_sources
);
   import kmms_pkg::*;

   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   cmd_type             front_cmd;
   cmd_type             queue_cmd;
   logic [CNT_W-1:0]    active_count;
   logic                queue_empty;
   logic                queue_pop;
   logic                rsp_valid;
   rsp_type             rsp;

   kmms_front #(.MAX_SOURCES(MAX_SOURCES)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_source_index   (req_source_index),
      .req_end_of_source  (req_end_of_source),
      .req_reference_id   (req_reference_id),
      .req_position       (req_position),
      .req_record_flags   (req_record_flags),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_active_sources (csr_active_sources),
      .cmd                (front_cmd),
      .active_count       (active_count)
   );

   kmms_cmd_fifo u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .din   (front_cmd),
      .pop   (queue_pop),
      .empty (queue_empty),
      .dout  (queue_cmd)
   );

   kmms_back #(.MAX_SOURCES(MAX_SOURCES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .active_count (active_count),
      .cmd_valid    (!queue_empty),
      .cmd          (queue_cmd),
      .cmd_pop      (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_pop      (rsp_pop),
      .rsp          (rsp)
   );

   assign rsp_empty           = !rsp_valid;
   assign rsp_selected_source = rsp.selected_source;
   assign rsp_all_done        = rsp.all_done;
   assign rsp_load_error      = rsp.load_error;

endmodule
`default_nettype wire

/* dv/merge_select_checker.sv */
// Checker for the k-way merge selector: predicts each selection, compares each result transfer.
`default_nettype none
module merge_select_checker #(
   parameter int SOURCES = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   input  wire                req_full,
   input  wire  [3:0]         req_source_index,
   input  wire                req_end_of_source,
   input  wire  signed [24:0] req_reference_id,
   input  wire  signed [31:0] req_position,
   input  wire  [15:0]        req_record_flags,
   input  wire                rsp_empty,
   input  wire                rsp_pop,
   input  wire  [3:0]         rsp_selected_source,
   input  wire                rsp_all_done,
   input  wire                rsp_load_error,
   input  wire                csr_valid,
   input  wire                csr_ready,
   input  wire  [4:0]         csr_active_sources,
   output int                 outstanding,
   output int                 mismatches
);

   logic [kmms_pkg::KEY_W-1:0] head_key [SOURCES];
   logic [SOURCES-1:0]         loaded;
   logic [4:0]                 width_reg;
   kmms_pkg::rsp_type          expected_picks [$];

   function automatic logic [kmms_pkg::KEY_W-1:0] pack_head(input logic ended,
                                                            input logic signed [24:0] rid,
                                                            input logic signed [31:0] pos,
                                                            input logic [15:0] flags);
      if (ended)
         return kmms_pkg::KEY_ENDED;
      if (rid < 0 || pos < 0)
         return kmms_pkg::KEY_UNMAPPED;
      return ({40'd0, rid[23:0]} << kmms_pkg::REF_SHIFT) |
             ({33'd0, pos[30:0]} << kmms_pkg::POS_SHIFT) |
             {48'd0, flags & kmms_pkg::REVERSE_BIT};
   endfunction

   task automatic take_load();
      int                         n;
      int                         pick;
      logic [kmms_pkg::KEY_W-1:0] best;
      kmms_pkg::rsp_type          res;
      n = (width_reg < 2) ? 2 : (width_reg > SOURCES) ? SOURCES : int'(width_reg);
      res = '0;
      if (req_source_index >= n || loaded[req_source_index]) begin
         res.load_error = 1'b1;
         expected_picks = {expected_picks, res};
         return;
      end
      head_key[req_source_index] = pack_head(req_end_of_source, req_reference_id,
                                             req_position, req_record_flags);
      loaded[req_source_index] = 1'b1;
      for (int i = 0; i < n; i++)
         if (!loaded[i])
            return;
      best = kmms_pkg::KEY_ENDED;
      pick = -1;
      // strict compare keeps the lowest index on ties
      for (int i = 0; i < n; i++)
         if (head_key[i] < best) begin
            best = head_key[i];
            pick = i;
         end
      if (pick < 0) begin
         loaded = '0;
         res.all_done = 1'b1;
      end else begin
         loaded[pick] = 1'b0;
         res.selected_source = pick[3:0];
      end
      expected_picks = {expected_picks, res};
   endtask

   task automatic check_result();
      kmms_pkg::rsp_type want;
      if (expected_picks.size() == 0) begin
         $display("%0t: result with none expected: sel %0d done %0b err %0b", $time,
                  rsp_selected_source, rsp_all_done, rsp_load_error);
         mismatches++;
         return;
      end
      want = expected_picks.pop_front();
      if ({rsp_selected_source, rsp_all_done, rsp_load_error} !== want) begin
         $display("%0t: expected sel %0d done %0b err %0b, got sel %0d done %0b err %0b",
                  $time, want.selected_source, want.all_done, want.load_error,
                  rsp_selected_source, rsp_all_done, rsp_load_error);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loaded = '0;
         width_reg = 5'd2;
         expected_picks.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready)
            width_reg = csr_active_sources;
         if (rsp_pop && !rsp_empty)
            check_result();
         if (req_push && !req_full)
            take_load();
      end
      outstanding <= expected_picks.size();
   end

endmodule
`default_nettype wire

/* dv/kway_merge_min_select_top_test.sv */
// Testbench top for the k-way merge selector: drives loads, width changes, pops; gives verdict.
`default_nettype none
module kway_merge_min_select_top_test;

   localparam int SOURCES = 16;
   localparam int PHASES = 16;
   localparam int PHASE_LOADS = 105;
   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT = 2000;
   // widths for the first phases, lowest slot first: 16, 0, 31, 3, 1, 17, 2, 8
   localparam logic [39:0] WIDTH_PLAN = {5'd8, 5'd2, 5'd17, 5'd1, 5'd3, 5'd31, 5'd0, 5'd16};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic [3:0]         req_source_index = '0;
   logic               req_end_of_source = 1'b0;
   logic signed [24:0] req_reference_id = '0;
   logic signed [31:0] req_position = '0;
   logic [15:0]        req_record_flags = '0;
   logic               rsp_pop = 1'b0;
   logic               csr_valid = 1'b0;
   logic [4:0]         csr_active_sources = 5'd2;
   wire                req_full;
   wire                rsp_empty;
   wire  [3:0]         rsp_selected_source;
   wire                rsp_all_done;
   wire                rsp_load_error;
   wire                csr_ready;
   int                 pending_picks;
   int                 mismatches;

   // streams that may take a head record, as seen from the popped results
   logic [SOURCES-1:0] open_sources = '1;
   int                 merge_width = 2;
   bit                 req_gaps = 1'b1;
   bit                 rsp_gaps = 1'b1;
   int                 idle_cycles = 0;

   always #1 clock = ~clock;

   kway_merge_min_select_top #(
      .MAX_SOURCES(SOURCES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_source_index(req_source_index),
      .req_end_of_source(req_end_of_source),
      .req_reference_id(req_reference_id),
      .req_position(req_position),
      .req_record_flags(req_record_flags),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_selected_source(rsp_selected_source),
      .rsp_all_done(rsp_all_done),
      .rsp_load_error(rsp_load_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_active_sources(csr_active_sources)
   );

   merge_select_checker #(
      .SOURCES(SOURCES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_source_index(req_source_index),
      .req_end_of_source(req_end_of_source),
      .req_reference_id(req_reference_id),
      .req_position(req_position),
      .req_record_flags(req_record_flags),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_selected_source(rsp_selected_source),
      .rsp_all_done(rsp_all_done),
      .rsp_load_error(rsp_load_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_active_sources(csr_active_sources),
      .outstanding(pending_picks),
      .mismatches(mismatches)
   );

   function automatic int width_of(input logic [4:0] value);
      if (value < 2)
         return 2;
      if (value > SOURCES)
         return SOURCES;
      return int'(value);
   endfunction

   function automatic logic [SOURCES-1:0] span(input int n);
      logic [SOURCES-1:0] m;
      m = '0;
      for (int i = 0; i < n; i++)
         m[i] = 1'b1;
      return m;
   endfunction

   function automatic int pick_open();
      int cands[$];
      for (int i = 0; i < merge_width; i++)
         if (open_sources[i])
            cands = {cands, i};
      return cands[$urandom_range(0, cands.size() - 1)];
   endfunction

   task automatic send_item(input logic [3:0] idx, input logic ended,
                            input logic signed [24:0] rid, input logic signed [31:0] pos,
                            input logic [15:0] flags);
      int gap;
      gap = req_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_source_index <= idx;
      req_end_of_source <= ended;
      req_reference_id <= rid;
      req_position <= pos;
      req_record_flags <= flags;
      do @(posedge clock); while (req_full);
      if (idx < merge_width && open_sources[idx])
         open_sources[idx] = 1'b0;
   endtask

   task automatic await_open(input logic [SOURCES-1:0] m);
      if ((open_sources & m) == '0) begin
         req_push <= 1'b0;
         while ((open_sources & m) == '0) @(posedge clock);
      end
   endtask

   // a load that completes no set gives no result, so allow the engine to settle too
   task automatic await_idle();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_picks != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [4:0]         value;
      logic [31:0]        r;
      logic signed [24:0] rid;
      logic signed [31:0] pos;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset width of two streams
      await_open(16'h0001);
      send_item(4'd0, 1'b0, 25'sd0, 32'sd0, 16'h0010);
      await_open(16'h0002);
      send_item(4'd1, 1'b0, 25'sd0, 32'sd0, 16'hffef);
      await_open(16'h0002);
      send_item(4'd1, 1'b0, 25'sd0, 32'sd0, 16'h0010);
      send_item(4'd1, 1'b0, 25'sd7, 32'sd9, 16'h0000);
      send_item(4'd5, 1'b0, 25'sd1, 32'sd1, 16'h0000);
      send_item(4'd15, 1'b0, 25'sd0, 32'sd0, 16'h0010);
      await_open(16'h0001);
      send_item(4'd0, 1'b0, -25'sd1, 32'sd5, 16'h0000);
      await_open(16'h0002);
      send_item(4'd1, 1'b0, 25'sh0ffffff, 32'sh7fffffff, 16'hffff);
      await_open(16'h0002);
      send_item(4'd1, 1'b0, 25'sd3, 32'sh80000000, 16'h0000);
      await_open(16'h0001);
      send_item(4'd0, 1'b1, 25'sh1000000, -32'sd1, 16'hffff);
      await_open(16'h0002);
      send_item(4'd1, 1'b1, 25'sd0, 32'sd0, 16'h0000);
      await_open(16'h0001);
      send_item(4'd0, 1'b1, 25'sd2, 32'sd2, 16'h0010);
      await_open(16'h0002);
      send_item(4'd1, 1'b0, 25'sh1000000, 32'sh7fffffff, 16'h0000);
      await_open(16'h0002);
      send_item(4'd1, 1'b1, 25'sd0, 32'sd0, 16'h0000);

      for (int p = 0; p < PHASES; p++) begin
         await_idle();
         r = $urandom;
         value = (p < 8) ? WIDTH_PLAN[p*5 +: 5] : r[4:0];
         if ((open_sources & span(width_of(value))) == '0) begin
            // every stream under the new width holds a head with no selection due:
            // end the current merge first
            forever begin
               await_open(span(merge_width));
               if ((open_sources & span(merge_width)) == span(merge_width))
                  break;
               r = $urandom;
               send_item(4'(pick_open()), 1'b1, r[24:0], $urandom, r[31:16]);
            end
            await_idle();
         end
         csr_valid <= 1'b1;
         csr_active_sources <= value;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         merge_width = width_of(value);
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);

         for (int k = 0; k < PHASE_LOADS; k++) begin
            r = $urandom;
            if ($urandom_range(0, 7) == 0) begin
               // stray load: mostly hits a loaded or out-of-range stream
               send_item(4'($urandom_range(0, 15)), r[4], 25'($urandom), $urandom,
                         r[31:16]);
            end else begin
               await_open(span(merge_width));
               case ($urandom_range(0, 7))
                  0, 1, 2: begin
                     rid = 25'($urandom_range(0, 2));
                     pos = $urandom_range(0, 3);
                  end
                  3: begin
                     rid = 25'($urandom_range(0, 24'hffffff));
                     pos = $urandom_range(0, 32'h7fffffff);
                  end
                  4: begin
                     rid = {1'b1, r[23:0]};
                     pos = $urandom;
                  end
                  5: begin
                     rid = 25'($urandom_range(0, 15));
                     pos = {1'b1, r[30:0]};
                  end
                  6: begin
                     rid = r[0] ? 25'sh0ffffff : 25'sd0;
                     pos = r[1] ? 32'sh7fffffff : 32'sd0;
                  end
                  default: begin
                     rid = r[24:0];
                     pos = $urandom;
                  end
               endcase
               send_item(4'(pick_open()), $urandom_range(0, merge_width + 1) == 0, rid, pos,
                         16'($urandom));
            end
         end
      end

      await_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_picks == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side: pop with random stalls and track which streams were released
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = rsp_gaps ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (rsp_all_done)
            open_sources = '1;
         else if (!rsp_load_error)
            open_sources[rsp_selected_source] = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
`default_nettype wire

/* filelist.f */
rtl/kmms_pkg.sv
rtl/kmms_front.sv
rtl/kmms_cmd_fifo.sv
rtl/kmms_back.sv
rtl/kway_merge_min_select_top.sv
dv/merge_select_checker.sv
dv/kway_merge_min_select_top_test.sv
